// ----- design/mdte_pkg.sv -----
// Shared types, codes and tables for the masked date/time entry block.
`timescale 1ns / 1ps
package mdte_pkg;

  // Request codes carried in s_tuser
  localparam logic [1:0] REQ_TYPE  = 2'd0;
  localparam logic [1:0] REQ_BACK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_YEAR_MIN = 2'd1;
  localparam logic [1:0] CFG_YEAR_MAX = 2'd2;

  localparam logic [13:0] YEAR_MIN_RST = 14'd2020;
  localparam logic [13:0] YEAR_MAX_RST = 14'd2099;

  localparam logic [3:0] TIME_SLOTS = 4'd4;
  localparam logic [3:0] DATE_SLOTS = 4'd8;
  localparam logic [3:0] MAX_KEY    = 4'd9;

  typedef logic [7:0][3:0] digit_arr_t;

  // Field state after one request
  typedef struct packed {
    logic       accepted;
    logic [3:0] text_length;
    logic [3:0] digit_count;
    logic       complete;
  } field_res_t;

  // Range check outcome
  typedef struct packed {
    logic        valid_res;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic [13:0] year_value;
  } check_res_t;

  // Characters shown for a digit count, separators included
  function automatic logic [3:0] shown_len(input logic mode, input logic [3:0] n);
    logic [3:0] r;
    r = 4'd0;
    if (!mode) begin
      case (n)
        4'd0:    r = 4'd0;
        4'd1:    r = 4'd1;
        4'd2:    r = 4'd3;
        4'd3:    r = 4'd4;
        default: r = 4'd5;
      endcase
    end else begin
      case (n)
        4'd0:    r = 4'd0;
        4'd1:    r = 4'd1;
        4'd2:    r = 4'd3;
        4'd3:    r = 4'd4;
        4'd4:    r = 4'd6;
        4'd5:    r = 4'd7;
        4'd6:    r = 4'd8;
        4'd7:    r = 4'd9;
        default: r = 4'd10;
      endcase
    end
    return r;
  endfunction

  // Days in a month, zero for a month out of range
  function automatic logic [4:0] month_days(input logic [6:0] mo, input logic leap);
    logic [4:0] r;
    case (mo)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
      7'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/mdte_field_ctrl.sv -----
// Digit store and digit count, updated by one request per cycle while go is high.
`timescale 1ns / 1ps
module mdte_field_ctrl
  import mdte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       mode,
  input  logic [1:0] req_type,
  input  logic [3:0] key_value,
  output field_res_t res,
  output digit_arr_t digits
);

  digit_arr_t store;
  logic [3:0] held_digits;
  logic [3:0] held_digits_next;
  logic [3:0] cap;
  logic [3:0] n;
  logic       wr;
  logic       acc;

  // Count saturated at the current mask capacity
  always_comb begin
    cap = mode ? DATE_SLOTS : TIME_SLOTS;
    n   = (held_digits > cap) ? cap : held_digits;
  end

  // Request decode
  always_comb begin
    held_digits_next = held_digits;
    wr               = 1'b0;
    acc              = 1'b0;
    case (req_type)
      REQ_TYPE: begin
        held_digits_next = n;
        if (key_value <= MAX_KEY && n < cap) begin
          held_digits_next = n + 4'd1;
          wr               = 1'b1;
          acc              = 1'b1;
        end
      end
      REQ_BACK: begin
        held_digits_next = n;
        if (n != 4'd0) begin
          held_digits_next = n - 4'd1;
          acc              = 1'b1;
        end
      end
      REQ_CLEAR: begin
        held_digits_next = 4'd0;
        acc              = (held_digits != 4'd0);
      end
      default: begin
        held_digits_next = n;
      end
    endcase
  end

  // Digits with the one being typed forwarded
  always_comb begin
    digits = store;
    if (wr) begin
      digits[n[2:0]] = key_value;
    end
  end

  always_comb begin
    res.accepted    = acc;
    res.digit_count = (req_type == REQ_TYPE || req_type == REQ_BACK ||
                       req_type == REQ_CLEAR) ? held_digits_next : n;
    res.text_length = shown_len(mode, res.digit_count);
    res.complete    = (res.digit_count == cap);
  end

  // Store write
  always_ff @(posedge clk) begin
    if (go && wr) begin
      store[n[2:0]] <= key_value;
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_digits <= 4'd0;
    end else if (go && (req_type == REQ_TYPE || req_type == REQ_BACK ||
                        req_type == REQ_CLEAR)) begin
      held_digits <= held_digits_next;
    end
  end

endmodule

// ----- design/mdte_validator.sv -----
// Decodes the held digits and checks time or calendar ranges.
`timescale 1ns / 1ps
module mdte_validator
  import mdte_pkg::*;
(
  input  logic        mode,
  input  logic        complete,
  input  logic [13:0] year_min,
  input  logic [13:0] year_max,
  input  digit_arr_t  digits,
  output check_res_t  res
);

  logic [6:0]  a;
  logic [6:0]  b;
  logic [6:0]  yr_hi;
  logic [6:0]  yr_lo;
  logic [13:0] y;
  logic        leap;
  logic        ok;

  // Two-digit groups and the full year
  always_comb begin
    a     = 7'(digits[0]) * 7'd10 + 7'(digits[1]);
    b     = 7'(digits[2]) * 7'd10 + 7'(digits[3]);
    yr_hi = 7'(digits[4]) * 7'd10 + 7'(digits[5]);
    yr_lo = 7'(digits[6]) * 7'd10 + 7'(digits[7]);
    y     = 14'(yr_hi) * 14'd100 + 14'(yr_lo);
  end

  // Gregorian rule: century years need the century divisible by four
  always_comb begin
    leap = (yr_lo != 7'd0) ? (yr_lo[1:0] == 2'd0) : (yr_hi[1:0] == 2'd0);
  end

  always_comb begin
    if (!mode) begin
      ok = complete && (a <= 7'd23) && (b <= 7'd59);
    end else begin
      ok = complete && (y >= year_min) && (y <= year_max) &&
           (b >= 7'd1) && (b <= 7'd12) && (a >= 7'd1) &&
           (a <= 7'(month_days(b, leap)));
    end
    res.valid_res    = ok;
    res.first_value  = ok ? a : 7'd0;
    res.second_value = ok ? b : 7'd0;
    res.year_value   = (ok && mode) ? y : 14'd0;
  end

endmodule

// ----- design/masked_date_time_entry.sv -----
// A request is captured in the request register and its result in the result
// register. One request per cycle unless the output stalls; the field update
// and range checks sit between the request register and the result register.
// Stalls: s_tready falls only when both registers are full and m_tready is low.
// Reset (rst, synchronous): field emptied, entry_mode 0, years 2020..2099.
`timescale 1ns / 1ps
module masked_date_time_entry
  import mdte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_value[3:0], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted[0], text_length[4:1], digit_count[8:5], complete[9],
  // valid_res[10], first_value[17:11], second_value[24:18],
  // year_value[38:25], zero pad[39]
  output logic [39:0] m_tdata
);

  logic        entry_mode;
  logic [13:0] year_min;
  logic [13:0] year_max;

  logic        in_v;
  logic [1:0]  in_req;
  logic [3:0]  in_key;
  logic        out_v;
  logic [39:0] out_data;
  logic        go;

  field_res_t  fres;
  check_res_t  cres;
  digit_arr_t  digits;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_mode <= 1'b0;
      year_min   <= YEAR_MIN_RST;
      year_max   <= YEAR_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     entry_mode <= cfg_data[0];
        CFG_YEAR_MIN: year_min   <= cfg_data;
        CFG_YEAR_MAX: year_max   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Handshake
  assign go       = in_v && (!out_v || m_tready);
  assign s_tready = !in_v || go;
  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= s_tuser;
      in_key <= s_tdata[3:0];
    end
  end

  mdte_field_ctrl u_field (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .mode      (entry_mode),
    .req_type  (in_req),
    .key_value (in_key),
    .res       (fres),
    .digits    (digits)
  );

  mdte_validator u_check (
    .mode     (entry_mode),
    .complete (fres.complete),
    .year_min (year_min),
    .year_max (year_max),
    .digits   (digits),
    .res      (cres)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (go) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= {1'b0, cres.year_value, cres.second_value, cres.first_value,
                   cres.valid_res, fres.complete, fres.digit_count,
                   fres.text_length, fres.accepted};
    end
  end

endmodule

// ----- design/mdte_checker.sv -----
// Port-level checks for the masked date/time entry block, bound to the top.
`timescale 1ns / 1ps
module mdte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // No result straight after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Valid only on a complete field
  a_valid_complete: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> m_tdata[9])
    else $error("valid result on incomplete field");

  // Values zero when not valid
  a_zero_values: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[10]) |-> (m_tdata[38:11] == 28'd0))
    else $error("values given for an invalid field");

  // Count within the widest mask
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:5] <= 4'd8))
    else $error("digit count beyond mask");

endmodule

bind masked_date_time_entry mdte_checker u_mdte_checker (.*);
